>>> hw/rtl/assert_macros.svh
// assertion macros used by quad_float_add_sub.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/qfas_pkg.sv
// types and constants for the binary128 add/subtract block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qfas_pkg;

  localparam int unsigned FracBits = 112;
  localparam int unsigned SigBits  = 113;
  localparam int unsigned ExpBits  = 15;
  localparam logic [ExpBits-1:0] ExpMax = 15'h7fff;

  typedef enum logic [1:0] {
    ST_NORMAL    = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_ZERO      = 2'd3
  } status_t;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                sign;
    logic [ExpBits-1:0]  exp;
    logic [FracBits-1:0] frac;
  } binary128_t;

endpackage

`default_nettype wire

>>> hw/rtl/qfas_core.sv
// combinational binary128 add/subtract datapath with truncation
// depends on qfas_pkg
`timescale 1ns / 1ps
`default_nettype none

module qfas_core
  import qfas_pkg::*;
(
  input  wire logic       op_sub,
  input  wire binary128_t a,
  input  wire binary128_t b_in,
  output binary128_t      r,
  output status_t         status
);

  binary128_t          b, x, y;
  logic                a_zero, b_zero, b_larger;
  logic [ExpBits-1:0]  d;
  logic [SigBits-1:0]  sx, sy;
  logic [SigBits:0]    sum;
  logic [6:0]          lz;
  logic [SigBits-1:0]  norm;
  logic                found;

  always_comb begin
    b      = b_in;
    b.sign = b_in.sign ^ op_sub;
    a_zero = (a.exp == '0) && (a.frac == '0);
    b_zero = (b.exp == '0) && (b.frac == '0);
    b_larger = {b.exp, b.frac} > {a.exp, a.frac};
    x = b_larger ? b : a;
    y = b_larger ? a : b;
    d  = x.exp - y.exp;
    sx = {1'b1, x.frac};
    sy = {1'b1, y.frac} >> d;
    if (x.sign == y.sign) sum = {1'b0, sx} + {1'b0, sy};
    else                  sum = {1'b0, sx} - {1'b0, sy};
    // leading zero count over the 113-bit significand
    lz = '0;
    found = 1'b0;
    for (int i = SigBits - 1; i >= 0; i--) begin
      if (!found && sum[i]) begin
        found = 1'b1;
        lz = 7'(SigBits - 1 - i);
      end
    end
    norm = sum[SigBits-1:0] << lz;
    // result selection
    r = x;
    status = ST_NORMAL;
    if (a_zero) begin
      r = b;
    end else if (b_zero) begin
      r = a;
    end else if (d > ExpBits'(FracBits)) begin
      r = x;
    end else if (sum == '0) begin
      r = '0;
      status = ST_ZERO;
    end else if (sum[SigBits]) begin
      if ({1'b0, x.exp} + 16'd1 >= {1'b0, ExpMax}) begin
        r = '{sign: x.sign, exp: ExpMax, frac: '0};
        status = ST_OVERFLOW;
      end else begin
        r = '{sign: x.sign, exp: x.exp + 15'd1, frac: sum[SigBits-1:1]};
      end
    end else if (x.exp <= ExpBits'(lz)) begin
      r = '0;
      status = ST_UNDERFLOW;
    end else begin
      r = '{sign: x.sign, exp: x.exp - ExpBits'(lz), frac: norm[FracBits-1:0]};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/quad_float_add_sub.sv
// channel | fields (low bit first)                              | width
// in      | opcode a_sign a_exp a_frac_hi a_frac_lo b_* (tdata)  | 264
// out     | r_sign r_exp r_frac_hi r_frac_lo status (tdata)     | 136
// one item per cycle while out_tready is high: input register, single-pass datapath, result register
// transferred inputs go to the input register, their results then to the result register
// a stalled result holds; input stays ready while the result stage can drain
// rst_n synchronous active low, clears the valid bits only
// depends on qfas_pkg, qfas_core, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module quad_float_add_sub
  import qfas_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // opcode, a_sign, a_exp, a_frac_hi, a_frac_lo, b_sign, b_exp, b_frac_hi, b_frac_lo
  input  wire logic [263:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // r_sign, r_exp, r_frac_hi, r_frac_lo, status
  output logic [135:0]      out_tdata
);

  logic         in_v_r, out_v_r;
  logic [256:0] in_d_r;
  binary128_t   a, b, r;
  status_t      st;
  logic         adv_out, adv_in;
  logic [129:0] res_r;

  assign adv_out   = in_v_r && (!out_v_r || out_tready);
  assign adv_in    = !in_v_r || adv_out;
  assign in_tready = adv_in;

  // unpack operands
  assign a = '{sign: in_d_r[1], exp: in_d_r[16:2], frac: {in_d_r[64:17], in_d_r[128:65]}};
  assign b = '{sign: in_d_r[129], exp: in_d_r[144:130],
               frac: {in_d_r[192:145], in_d_r[256:193]}};

  qfas_core u_core (
    .op_sub (in_d_r[0]),
    .a      (a),
    .b_in   (b),
    .r      (r),
    .status (st)
  );

  // input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv_in) in_v_r <= in_tvalid;
      if (adv_out) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
    if (adv_in && in_tvalid) in_d_r <= in_tdata[256:0];
    if (adv_out) res_r <= {st, r.frac[63:0], r.frac[111:64], r.exp, r.sign};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, res_r};

  `ASSERT_NEXT(a_done_valid, clk, rst_n, adv_out, out_tvalid, "result lost")
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(res_r),
    "stalled result changed")
  `ASSERT_CLK(a_status, clk, rst_n,
    !out_tvalid || res_r[129:128] == ST_NORMAL || res_r[127:16] == '0, "special frac not zero")

endmodule

`default_nettype wire
